// File: rtl/hcs_pkg.sv
`timescale 1ns / 1ps
// Hall commutation sequencer package: widths, register indexes, lookup tables, result type.
package hcs_pkg;

	localparam int HallW    = 3;
	localparam int StepW    = 3;
	localparam int PhaseW   = 2;
	localparam int PolW     = 3;
	localparam int LimitW   = 8;
	localparam int CountW   = 32;
	localparam int CfgIdxW  = 1;
	localparam int CfgDataW = 8;

	localparam logic [CfgIdxW-1:0] REG_REVERSE_DIRECTION    = 1'b0;
	localparam logic [CfgIdxW-1:0] REG_SEQUENCE_ERROR_LIMIT = 1'b1;

	localparam logic [LimitW-1:0] LIMIT_RESET = 8'd5;

	localparam logic [StepW-1:0] STEP_NONE  = 3'd0;
	localparam logic [StepW-1:0] STEP_FIRST = 3'd1;
	localparam logic [StepW-1:0] STEP_LAST  = 3'd6;

	typedef logic [HallW-1:0] hall_t;
	typedef logic [StepW-1:0] step_t;

	typedef struct packed {
		step_t              rotor_step;
		step_t              drive_step;
		logic [PhaseW-1:0]  pwm_phase;
		logic [PolW-1:0]    low_side_high;
		logic               hall_invalid;
		logic               sequence_fault;
		logic [CountW-1:0]  event_count;
	} result_t;

	// Hall code to rotor step, forward rotation
	function automatic step_t fwd_map(input hall_t code);
		step_t s;
		case (code)
			3'd1:    s = 3'd4;
			3'd2:    s = 3'd6;
			3'd3:    s = 3'd5;
			3'd4:    s = 3'd2;
			3'd5:    s = 3'd3;
			3'd6:    s = 3'd1;
			default: s = STEP_NONE;
		endcase
		return s;
	endfunction

	// Hall code to rotor step, backward rotation
	function automatic step_t bwd_map(input hall_t code);
		step_t s;
		case (code)
			3'd1:    s = 3'd1;
			3'd2:    s = 3'd3;
			3'd3:    s = 3'd2;
			3'd4:    s = 3'd5;
			3'd5:    s = 3'd6;
			3'd6:    s = 3'd4;
			default: s = STEP_NONE;
		endcase
		return s;
	endfunction

	function automatic logic [PhaseW-1:0] pwm_of_step(input step_t s);
		logic [PhaseW-1:0] p;
		case (s)
			3'd2, 3'd3: p = 2'd2;
			3'd4, 3'd5: p = 2'd1;
			default:    p = 2'd0;
		endcase
		return p;
	endfunction

	function automatic logic [PolW-1:0] pol_of_step(input step_t s);
		logic [PolW-1:0] p;
		case (s)
			3'd1, 3'd4: p = 3'd4;
			3'd2, 3'd5: p = 3'd1;
			3'd3, 3'd6: p = 3'd2;
			default:    p = 3'd0;
		endcase
		return p;
	endfunction

endpackage

// File: rtl/hcs_core.sv
`timescale 1ns / 1ps
// Commutation core: step decode, sequence checker state, drive step and event counter.
module hcs_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  hcs_pkg::hall_t              hall_code,
	input  logic                        check_enable,
	input  logic                        reverse_direction,
	input  logic [hcs_pkg::LimitW-1:0]  error_limit,
	output hcs_pkg::result_t            result
);
	import hcs_pkg::*;

	step_t              position_q, last_step_q;
	logic               last_valid_q;
	logic [LimitW-1:0]  miss_count_q;
	logic [CountW-1:0]  commutations_q;

	step_t              step, expect_step, position_d, last_step_d, drive;
	logic               invalid, seq_ok, valid_eff, last_valid_d, fault;
	logic [LimitW-1:0]  miss_eff, miss_bump, miss_d;
	logic [CountW-1:0]  count_d;

	always_comb begin
		step    = reverse_direction ? bwd_map(hall_code) : fwd_map(hall_code);
		invalid = (step == STEP_NONE);

		position_d = invalid ? position_q : step;

		// checking disabled restarts the checker
		valid_eff = check_enable & last_valid_q;
		miss_eff  = check_enable ? miss_count_q : '0;

		if (!reverse_direction)
			expect_step = (last_step_q == STEP_LAST) ? STEP_FIRST : last_step_q + 3'd1;
		else
			expect_step = (last_step_q == STEP_FIRST) ? STEP_LAST : last_step_q - 3'd1;
		seq_ok = (last_step_q >= STEP_FIRST) && (last_step_q <= STEP_LAST) &&
			!invalid && (step <= STEP_LAST) && (step == expect_step);

		last_step_d  = last_step_q;
		last_valid_d = 1'b1;
		miss_d       = miss_eff;
		fault        = 1'b0;
		miss_bump    = seq_ok ? '0 : miss_eff + 8'd1;
		if (!valid_eff) begin
			last_step_d = step;
		end else if (miss_bump < error_limit) begin
			last_step_d = step;
			miss_d      = miss_bump;
		end else begin
			miss_d       = '0;
			fault        = 1'b1;
			last_valid_d = seq_ok;
		end

		if (!reverse_direction)
			drive = (position_d >= STEP_LAST) ? STEP_FIRST : position_d + 3'd1;
		else
			drive = (position_d <= STEP_FIRST || position_d > STEP_LAST) ?
				STEP_LAST : position_d - 3'd1;

		count_d = commutations_q + 32'd1;

		result.rotor_step     = step;
		result.drive_step     = drive;
		result.pwm_phase      = pwm_of_step(drive);
		result.low_side_high  = pol_of_step(drive);
		result.hall_invalid   = invalid;
		result.sequence_fault = fault;
		result.event_count    = count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q     <= STEP_NONE;
			last_step_q    <= STEP_NONE;
			last_valid_q   <= 1'b0;
			miss_count_q   <= '0;
			commutations_q <= '0;
		end else if (advance) begin
			position_q     <= position_d;
			last_step_q    <= last_step_d;
			last_valid_q   <= last_valid_d;
			miss_count_q   <= miss_d;
			commutations_q <= count_d;
		end
	end

endmodule

// File: rtl/hall_commutation_sequencer.sv
`timescale 1ns / 1ps
// Hall commutation sequencer top level: config registers, input register, result register.
//
//   channel   signals                                   direction
//   input     in_valid, in_stall, hall_code,            beat in, stall out
//             check_enable
//   output    out_valid, out_stall, rotor_step, ...     beat out, stall in
//   config    cfg_we, cfg_index, cfg_data               write only
//
// One beat per clock sustained while out_stall is low. A beat lands in the
// input register, is decoded by one pass through the core while the checker
// state updates, and lands in the result register.
// Reset clears checker state, event count and valid flags; the limit resets to 5.
// The input register accepts a new beat whenever it is empty or moving on, so a
// held result only stalls the input once both registers are full.
module hall_commutation_sequencer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  hcs_pkg::hall_t                 hall_code,
	input  logic                           check_enable,
	output logic                           out_valid,
	input  logic                           out_stall,
	output hcs_pkg::step_t                 rotor_step,
	output hcs_pkg::step_t                 drive_step,
	output logic [hcs_pkg::PhaseW-1:0]     pwm_phase,
	output logic [hcs_pkg::PolW-1:0]       low_side_high,
	output logic                           hall_invalid,
	output logic                           sequence_fault,
	output logic [hcs_pkg::CountW-1:0]     event_count,
	input  logic                           cfg_we,
	input  logic [hcs_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [hcs_pkg::CfgDataW-1:0]   cfg_data
);
	import hcs_pkg::*;

	// configuration registers
	logic              reverse_direction_q;
	logic [LimitW-1:0] sequence_error_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reverse_direction_q    <= 1'b0;
			sequence_error_limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_REVERSE_DIRECTION:    reverse_direction_q    <= cfg_data[0];
				REG_SEQUENCE_ERROR_LIMIT: sequence_error_limit_q <= cfg_data[LimitW-1:0];
				default: ;
			endcase
		end
	end

	// input register
	logic    valid_s1;
	hall_t   hall_code_s1;
	logic    check_enable_s1;
	logic    advance;
	logic    take_in;

	// core result moves on when the result register is empty or being drained
	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign take_in  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (take_in)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			hall_code_s1    <= hall_code;
			check_enable_s1 <= check_enable;
		end
	end

	result_t result;

	hcs_core u_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.advance           (advance),
		.hall_code         (hall_code_s1),
		.check_enable      (check_enable_s1),
		.reverse_direction (reverse_direction_q),
		.error_limit       (sequence_error_limit_q),
		.result            (result)
	);

	// result register
	logic    out_valid_q;
	result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_q <= result;
	end

	assign out_valid      = out_valid_q;
	assign rotor_step     = result_q.rotor_step;
	assign drive_step     = result_q.drive_step;
	assign pwm_phase      = result_q.pwm_phase;
	assign low_side_high  = result_q.low_side_high;
	assign hall_invalid   = result_q.hall_invalid;
	assign sequence_fault = result_q.sequence_fault;
	assign event_count    = result_q.event_count;

endmodule
